[src/hswc_pkg.sv]
`default_nettype none

package hswc_pkg;

    localparam int MIN_W         = 11;
    localparam int CODE_W        = 8;
    localparam int OFFSET_W      = 8;
    localparam int IDX_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 11;
    localparam int MAX_SCHEDULES = 4;
    localparam int DAY_MINUTES   = 1440;

    localparam int NUM_SCHEDULES_DEF = 4;
    localparam int SLOT_MINUTES_DEF  = 6;

    localparam logic [MIN_W-1:0]    DAY_MIN         = MIN_W'(DAY_MINUTES);
    localparam logic [CODE_W-1:0]   START_CODE_RST  = '1;
    localparam logic [OFFSET_W-1:0] PREWARM_RST     = OFFSET_W'(30);
    localparam logic [OFFSET_W-1:0] LOOKAHEAD_RST   = OFFSET_W'(60);
    localparam logic [MIN_W-1:0]    COMFORT_RST     = MIN_W'(60);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_0   = 3'd0,
        REG_START_1   = 3'd1,
        REG_START_2   = 3'd2,
        REG_START_3   = 3'd3,
        REG_PREWARM   = 3'd4,
        REG_LOOKAHEAD = 3'd5,
        REG_COMFORT   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [MAX_SCHEDULES-1:0][CODE_W-1:0] start_code;
        logic [OFFSET_W-1:0]                  prewarm;
        logic [OFFSET_W-1:0]                  lookahead;
        logic [MIN_W-1:0]                     comfort;
    } cfg_t;

    typedef struct packed {
        logic             set;
        logic [MIN_W-1:0] on_minute;
        logic [MIN_W-1:0] off_minute;
    } win_t;

    typedef struct packed {
        logic [MIN_W-1:0] start_minute;
        logic [MIN_W-1:0] end_minute;
        logic             selected_valid;
        logic             any_set;
        logic             warm_now;
        logic             warm_soon;
    } res_t;

    // (a - b) mod 1440, both operands already below 1440
    function automatic logic [MIN_W-1:0] mod_day_sub(input logic [MIN_W-1:0] a,
                                                     input logic [MIN_W-1:0] b);
        logic [MIN_W:0] d;
        if (a >= b)
            d = {1'b0, a} - {1'b0, b};
        else
            d = {1'b0, a} + {1'b0, DAY_MIN} - {1'b0, b};
        return d[MIN_W-1:0];
    endfunction

    function automatic logic in_window(input logic [MIN_W-1:0] m,
                                       input logic [MIN_W-1:0] s,
                                       input logic [MIN_W-1:0] e);
        return mod_day_sub(m, s) < mod_day_sub(e, s);
    endfunction

endpackage

`default_nettype wire

[src/hswc_req_if.sv]
`default_nettype none

interface hswc_req_if;
    logic                        valid;
    logic                        ready;
    logic [hswc_pkg::MIN_W-1:0]  minute_of_day;
    logic [hswc_pkg::IDX_W-1:0]  schedule_index;

    modport source (output valid, output minute_of_day, output schedule_index,
                    input ready);
    modport sink   (input valid, input minute_of_day, input schedule_index,
                    output ready);
endinterface

`default_nettype wire

[src/hswc_rsp_if.sv]
`default_nettype none

interface hswc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [hswc_pkg::MIN_W-1:0]  start_minute;
    logic [hswc_pkg::MIN_W-1:0]  end_minute;
    logic                        selected_valid;
    logic                        any_set;
    logic                        warm_now;
    logic                        warm_soon;

    modport source (output valid, output start_minute, output end_minute,
                    output selected_valid, output any_set, output warm_now,
                    output warm_soon, input ready);
    modport sink   (input valid, input start_minute, input end_minute,
                    input selected_valid, input any_set, input warm_now,
                    input warm_soon, output ready);
endinterface

`default_nettype wire

[src/hswc_cfg_if.sv]
`default_nettype none

interface hswc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hswc_pkg::CFG_IDX_W-1:0]   index;
    logic [hswc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/hswc_cfg.sv]
`default_nettype none

module hswc_cfg (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hswc_cfg_if.sink       cfg,
    output hswc_pkg::cfg_t regs
);

    hswc_pkg::cfg_t cfg_reg;
    hswc_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (hswc_pkg::cfg_reg_t'(cfg.index))
                hswc_pkg::REG_START_0:
                    cfg_next.start_code[0] = cfg.data[hswc_pkg::CODE_W-1:0];
                hswc_pkg::REG_START_1:
                    cfg_next.start_code[1] = cfg.data[hswc_pkg::CODE_W-1:0];
                hswc_pkg::REG_START_2:
                    cfg_next.start_code[2] = cfg.data[hswc_pkg::CODE_W-1:0];
                hswc_pkg::REG_START_3:
                    cfg_next.start_code[3] = cfg.data[hswc_pkg::CODE_W-1:0];
                hswc_pkg::REG_PREWARM:
                    cfg_next.prewarm = cfg.data[hswc_pkg::OFFSET_W-1:0];
                hswc_pkg::REG_LOOKAHEAD:
                    cfg_next.lookahead = cfg.data[hswc_pkg::OFFSET_W-1:0];
                hswc_pkg::REG_COMFORT:
                    cfg_next.comfort = cfg.data[hswc_pkg::MIN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < hswc_pkg::MAX_SCHEDULES; k++)
                cfg_reg.start_code[k] <= hswc_pkg::START_CODE_RST;
            cfg_reg.prewarm   <= hswc_pkg::PREWARM_RST;
            cfg_reg.lookahead <= hswc_pkg::LOOKAHEAD_RST;
            cfg_reg.comfort   <= hswc_pkg::COMFORT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[src/hswc_window.sv]
`default_nettype none

module hswc_window #(
    parameter int SLOT_MINUTES = hswc_pkg::SLOT_MINUTES_DEF
) (
    input  wire logic [hswc_pkg::CODE_W-1:0]   start_code,
    input  wire logic [hswc_pkg::OFFSET_W-1:0] prewarm,
    input  wire logic [hswc_pkg::MIN_W-1:0]    comfort,
    output hswc_pkg::win_t                     win
);

    localparam int LAST_SLOT = hswc_pkg::DAY_MINUTES / SLOT_MINUTES - 1;
    localparam int SLOT_W    = $clog2(SLOT_MINUTES + 1);
    localparam int PROD_W    = hswc_pkg::CODE_W + SLOT_W;
    localparam int MW        = hswc_pkg::MIN_W;

    logic [PROD_W-1:0] prod;
    logic [MW-1:0]     base;
    logic [MW:0]       on_wide;
    logic [MW:0]       end_sum;
    logic [MW:0]       off_wide;

    assign prod = PROD_W'(start_code) * PROD_W'(SLOT_MINUTES);
    // only meaningful when the code is set, then base < 1440
    assign base = prod[MW-1:0];

    always_comb
    begin
        // wind back by the prewarm, wrapping before midnight
        if (base >= MW'(prewarm))
            on_wide = {1'b0, base} - (MW+1)'(prewarm);
        else
            on_wide = {1'b0, base} + {1'b0, hswc_pkg::DAY_MIN} - (MW+1)'(prewarm);

        // base + comfort can reach past two days
        end_sum = {1'b0, base} + {1'b0, comfort};
        if (end_sum >= (MW+1)'(2 * hswc_pkg::DAY_MINUTES))
            off_wide = end_sum - (MW+1)'(2 * hswc_pkg::DAY_MINUTES);
        else if (end_sum >= (MW+1)'(hswc_pkg::DAY_MINUTES))
            off_wide = end_sum - (MW+1)'(hswc_pkg::DAY_MINUTES);
        else
            off_wide = end_sum;

        win.set        = (start_code <= hswc_pkg::CODE_W'(LAST_SLOT));
        win.on_minute  = on_wide[MW-1:0];
        win.off_minute = off_wide[MW-1:0];
    end

endmodule

`default_nettype wire

[src/heating_schedule_window_check.sv]
`default_nettype none

// Channel  Dir  Payload                                          Beat when
// cfg      in   index[2:0], data[10:0]                           valid & ready
// req      in   minute_of_day[10:0], schedule_index[2:0]         valid & ready
// rsp      out  start_minute, end_minute, selected_valid,        valid & ready
//               any_set, warm_now, warm_soon
//
// Two register stages, request then result: a request beat passes through the
// request register, then the result register, to its response beat; one beat per cycle
// sustained while rsp is not stalled, all schedule windows evaluated in parallel between the stages.
// Reset clears both valid flags and loads the configuration defaults.
// A stalled rsp holds the result register; the request register still fills
// if empty, then holds until the result register drains.
module heating_schedule_window_check #(
    parameter int NUM_SCHEDULES = hswc_pkg::NUM_SCHEDULES_DEF,
    parameter int SLOT_MINUTES  = hswc_pkg::SLOT_MINUTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hswc_cfg_if.sink   cfg,
    hswc_req_if.sink   req,
    hswc_rsp_if.source rsp
);

    localparam int MW = hswc_pkg::MIN_W;

    hswc_pkg::cfg_t regs;

    logic                       req_valid_reg;
    logic [MW-1:0]              minute_reg;
    logic [hswc_pkg::IDX_W-1:0] index_reg;
    logic                       rsp_valid_reg;
    hswc_pkg::res_t             res_reg;
    hswc_pkg::res_t             res_next;

    logic advance;

    hswc_pkg::win_t win [hswc_pkg::MAX_SCHEDULES];

    logic [MW-1:0] now_min;
    logic [MW:0]   soon_sum;
    logic [MW-1:0] soon_min;

    hswc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    for (genvar k = 0; k < hswc_pkg::MAX_SCHEDULES; k++)
    begin : g_sched
        if (k < NUM_SCHEDULES)
        begin : g_on
            hswc_window #(
                .SLOT_MINUTES (SLOT_MINUTES)
            ) u_window (
                .start_code (regs.start_code[k]),
                .prewarm    (regs.prewarm),
                .comfort    (regs.comfort),
                .win        (win[k])
            );
        end
        else
        begin : g_off
            assign win[k] = '0;
        end
    end

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;

    always_comb
    begin
        now_min  = (minute_reg >= hswc_pkg::DAY_MIN) ? minute_reg - hswc_pkg::DAY_MIN
                                                     : minute_reg;
        soon_sum = {1'b0, now_min} + (MW+1)'(regs.lookahead);
        if (soon_sum >= {1'b0, hswc_pkg::DAY_MIN})
            soon_sum = soon_sum - {1'b0, hswc_pkg::DAY_MIN};
        soon_min = soon_sum[MW-1:0];

        res_next = '0;
        for (int k = 0; k < hswc_pkg::MAX_SCHEDULES; k++)
        begin
            if (win[k].set)
            begin
                res_next.any_set = 1'b1;
                if (hswc_pkg::in_window(now_min, win[k].on_minute, win[k].off_minute))
                    res_next.warm_now = 1'b1;
                if (hswc_pkg::in_window(soon_min, win[k].on_minute, win[k].off_minute))
                    res_next.warm_soon = 1'b1;
            end
        end

        if (index_reg < hswc_pkg::IDX_W'(hswc_pkg::MAX_SCHEDULES))
        begin
            if (win[index_reg[1:0]].set)
            begin
                res_next.selected_valid = 1'b1;
                res_next.start_minute   = win[index_reg[1:0]].on_minute;
                res_next.end_minute     = win[index_reg[1:0]].off_minute;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                req_valid_reg <= req.valid;
            if (!rsp_valid_reg || rsp.ready)
                rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            minute_reg <= req.minute_of_day;
            index_reg  <= req.schedule_index;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.start_minute   = res_reg.start_minute;
    assign rsp.end_minute     = res_reg.end_minute;
    assign rsp.selected_valid = res_reg.selected_valid;
    assign rsp.any_set        = res_reg.any_set;
    assign rsp.warm_now       = res_reg.warm_now;
    assign rsp.warm_soon      = res_reg.warm_soon;

    a_sel_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.selected_valid |-> rsp.any_set)
        else $error("selected schedule valid while no schedule set");

    a_unset_not_warm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.any_set |-> !rsp.warm_now && !rsp.warm_soon)
        else $error("warm flag raised with no schedule set");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.selected_valid |->
            rsp.start_minute == '0 && rsp.end_minute == '0)
        else $error("invalid selection carries nonzero times");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && rsp_valid_reg && !rsp.ready |=> req_valid_reg && rsp_valid_reg)
        else $error("stalled beat lost");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import hswc_pkg::*;

    localparam int NUM_SCHED       = NUM_SCHEDULES_DEF;
    localparam int SLOT_MIN        = SLOT_MINUTES_DEF;
    localparam int LAST_SLOT       = DAY_MINUTES / SLOT_MIN - 1;
    localparam int NUM_REGS        = 7;
    localparam int COMFORT_MAX     = 1184;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int MAX_GAP         = 20;
    localparam int MAX_STALL       = 12;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    localparam res_t UNSET_REPORT = '{start_minute: '0, end_minute: '0,
                                      selected_valid: 1'b0, any_set: 1'b0,
                                      warm_now: 1'b0, warm_soon: 1'b0};

    typedef enum int {STREAM, COIN, EVERY_FOURTH, STARVED} ready_mode_e;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [MIN_W-1:0]      minute;
        logic [IDX_W-1:0]      sel;
        logic                  has_fixed;
        res_t                  fixed;
    } step_t;

    logic clk;
    logic rst_n;

    hswc_cfg_if cfg_ch ();
    hswc_req_if req_ch ();
    hswc_rsp_if rsp_ch ();

    heating_schedule_window_check #(
        .NUM_SCHEDULES (NUM_SCHED),
        .SLOT_MINUTES  (SLOT_MIN)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cfg_t   sched_cfg;
    res_t   expected_reports[$];
    step_t  directed_steps[$];
    int     error_count = 0;
    int     idle_cycles = 0;
    int     burst_left  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Window of schedule k as on/off minutes; zero when unset or out of range
    function automatic bit schedule_window(input int k, output int on_m, output int off_m);
        int code;
        on_m  = 0;
        off_m = 0;
        if (k >= NUM_SCHED)
            return 1'b0;
        code = int'(sched_cfg.start_code[k]);
        if (code > LAST_SLOT)
            return 1'b0;
        on_m  = (code * SLOT_MIN + DAY_MINUTES - int'(sched_cfg.prewarm)) % DAY_MINUTES;
        off_m = (on_m + int'(sched_cfg.prewarm) + int'(sched_cfg.comfort)) % DAY_MINUTES;
        return 1'b1;
    endfunction

    function automatic bit minute_in_window(input int m, input int s, input int e);
        return ((m + DAY_MINUTES - s) % DAY_MINUTES) < ((e + DAY_MINUTES - s) % DAY_MINUTES);
    endfunction

    function automatic res_t predict_window_report(input logic [MIN_W-1:0] minute,
                                                   input logic [IDX_W-1:0] sel);
        int   now_m;
        int   soon_m;
        int   on_m;
        int   off_m;
        res_t r;
        r      = '0;
        now_m  = int'(minute) % DAY_MINUTES;
        soon_m = (now_m + int'(sched_cfg.lookahead)) % DAY_MINUTES;
        for (int k = 0; k < NUM_SCHED; k++)
        begin
            if (schedule_window(k, on_m, off_m))
            begin
                r.any_set = 1'b1;
                if (minute_in_window(now_m, on_m, off_m))
                    r.warm_now = 1'b1;
                if (minute_in_window(soon_m, on_m, off_m))
                    r.warm_soon = 1'b1;
            end
        end
        if (schedule_window(int'(sel), on_m, off_m))
        begin
            r.selected_valid = 1'b1;
            r.start_minute   = MIN_W'(on_m);
            r.end_minute     = MIN_W'(off_m);
        end
        return r;
    endfunction

    function automatic step_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
        step_t s;
        s          = '0;
        s.is_write = 1'b1;
        s.reg_idx  = idx;
        s.reg_data = value;
        return s;
    endfunction

    function automatic step_t query_row(input logic [MIN_W-1:0] minute,
                                        input logic [IDX_W-1:0] sel);
        step_t s;
        s        = '0;
        s.minute = minute;
        s.sel    = sel;
        return s;
    endfunction

    function automatic step_t fixed_row(input logic [MIN_W-1:0] minute,
                                        input logic [IDX_W-1:0] sel, input res_t r);
        step_t s;
        s           = query_row(minute, sel);
        s.has_fixed = 1'b1;
        s.fixed     = r;
        return s;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Drop both valids and hold until every report has come back
    task automatic quiesce();
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_START_0, REG_START_1, REG_START_2, REG_START_3:
                sched_cfg.start_code[idx[1:0]] = value[CODE_W-1:0];
            REG_PREWARM:   sched_cfg.prewarm   = value[OFFSET_W-1:0];
            REG_LOOKAHEAD: sched_cfg.lookahead = value[OFFSET_W-1:0];
            REG_COMFORT:   sched_cfg.comfort   = value[MIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_query(input logic [MIN_W-1:0] minute, input logic [IDX_W-1:0] sel,
                              input logic has_fixed, input res_t fixed);
        int gap;
        cfg_ch.valid <= 1'b0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid          <= 1'b1;
        req_ch.minute_of_day  <= minute;
        req_ch.schedule_index <= sel;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_reports.push_back(has_fixed ? fixed : predict_window_report(minute, sel));
    endtask

    initial
    begin
        step_t                 st;
        logic                  writing;
        logic [CFG_DATA_W-1:0] value;
        logic [MIN_W-1:0]      minute;
        logic [IDX_W-1:0]      sel;
        int                    on_m;
        int                    off_m;
        int                    edge_m;

        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.minute_of_day  <= '0;
        req_ch.schedule_index <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;

        for (int k = 0; k < MAX_SCHEDULES; k++)
            sched_cfg.start_code[k] = START_CODE_RST;
        sched_cfg.prewarm   = PREWARM_RST;
        sched_cfg.lookahead = LOOKAHEAD_RST;
        sched_cfg.comfort   = COMFORT_RST;

        // all schedules unset out of reset
        directed_steps.push_back(fixed_row(11'd0, 3'd0, UNSET_REPORT));
        directed_steps.push_back(fixed_row(11'd1439, 3'd7, UNSET_REPORT));
        directed_steps.push_back(fixed_row(11'd2047, 3'd3, UNSET_REPORT));
        // slot zero: window wraps across midnight
        directed_steps.push_back(write_row(REG_START_0, 11'd0));
        directed_steps.push_back(query_row(11'd1410, 3'd0));
        directed_steps.push_back(query_row(11'd0, 3'd0));
        directed_steps.push_back(query_row(11'd59, 3'd0));
        directed_steps.push_back(query_row(11'd60, 3'd0));
        directed_steps.push_back(query_row(11'd1409, 3'd0));
        directed_steps.push_back(query_row(11'd1440, 3'd0));
        directed_steps.push_back(query_row(11'd700, 3'd4));
        // last valid slot, first unset code, upper data bits dropped
        directed_steps.push_back(write_row(REG_START_1, 11'(LAST_SLOT)));
        directed_steps.push_back(write_row(REG_START_2, 11'(LAST_SLOT + 1)));
        directed_steps.push_back(write_row(REG_START_3, 11'h7FF));
        directed_steps.push_back(query_row(11'd1404, 3'd1));
        directed_steps.push_back(query_row(11'd1439, 3'd1));
        directed_steps.push_back(query_row(11'd0, 3'd2));
        directed_steps.push_back(query_row(11'd0, 3'd3));
        // zero length windows, no look-ahead
        directed_steps.push_back(write_row(REG_PREWARM, 11'd0));
        directed_steps.push_back(write_row(REG_COMFORT, 11'd0));
        directed_steps.push_back(write_row(REG_LOOKAHEAD, 11'd0));
        directed_steps.push_back(query_row(11'd0, 3'd0));
        directed_steps.push_back(query_row(11'd1434, 3'd1));
        // comfort beyond its range, unused register index ignored
        directed_steps.push_back(write_row(REG_PREWARM, 11'd255));
        directed_steps.push_back(write_row(REG_COMFORT, 11'd2047));
        directed_steps.push_back(write_row(REG_LOOKAHEAD, 11'd255));
        directed_steps.push_back(write_row(CFG_IDX_UNUSED, 11'd0));
        directed_steps.push_back(query_row(11'd0, 3'd0));
        directed_steps.push_back(query_row(11'd1000, 3'd1));
        directed_steps.push_back(query_row(11'd1185, 3'd0));
        directed_steps.push_back(query_row(11'd2047, 3'd5));
        // prewarm plus comfort of a full day: window empty again
        directed_steps.push_back(write_row(REG_COMFORT, 11'd1185));
        directed_steps.push_back(query_row(11'd100, 3'd0));
        directed_steps.push_back(query_row(11'd1300, 3'd1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        writing = 1'b0;
        foreach (directed_steps[i])
        begin
            st = directed_steps[i];
            if (st.is_write)
            begin
                if (!writing)
                    quiesce();
                writing = 1'b1;
                write_reg(st.reg_idx, st.reg_data);
            end
            else
            begin
                writing = 1'b0;
                send_query(st.minute, st.sel, st.has_fixed, st.fixed);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiesce();
            for (int r = 0; r < NUM_REGS; r++)
            begin
                case (phase)
                    0: value = '0;
                    1: value = (r <= REG_START_3) ? CFG_DATA_W'(LAST_SLOT)
                             : (r == REG_COMFORT) ? CFG_DATA_W'(COMFORT_MAX)
                             : CFG_DATA_W'(255);
                    default:
                        if (r <= REG_START_3)
                            value = ($urandom_range(0, 3) == 0)
                                    ? CFG_DATA_W'($urandom_range(LAST_SLOT + 1, 2047))
                                    : CFG_DATA_W'($urandom_range(0, LAST_SLOT));
                        else if (r == REG_COMFORT)
                            value = ($urandom_range(0, 7) == 0)
                                    ? CFG_DATA_W'($urandom_range(COMFORT_MAX + 1, 2047))
                                    : CFG_DATA_W'($urandom_range(0, COMFORT_MAX));
                        else
                            value = ($urandom_range(0, 7) == 0)
                                    ? CFG_DATA_W'($urandom_range(0, 2047))
                                    : CFG_DATA_W'($urandom_range(0, 255));
                endcase
                write_reg(CFG_IDX_W'(r), value);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom_range(0, 2047)));

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        // land on or near a window edge, now or at the look-ahead point
                        if (schedule_window($urandom_range(0, NUM_SCHED - 1), on_m, off_m))
                        begin
                            edge_m = $urandom_range(0, 1) ? on_m : off_m;
                            if ($urandom_range(0, 1))
                                edge_m -= int'(sched_cfg.lookahead);
                            minute = MIN_W'((edge_m + 2 * DAY_MINUTES
                                             + int'($urandom_range(0, 4)) - 2) % DAY_MINUTES);
                        end
                        else
                            minute = MIN_W'($urandom_range(0, DAY_MINUTES - 1));
                    end
                    1: minute = MIN_W'($urandom_range(0, 2047));
                    default: minute = MIN_W'($urandom_range(0, DAY_MINUTES - 1));
                endcase
                sel = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(NUM_SCHED, 7))
                                                  : IDX_W'($urandom_range(0, NUM_SCHED - 1));
                send_query(minute, sel, 1'b0, UNSET_REPORT);
                if (n == ITEMS_PER_PHASE / 2 && phase % 3 == 1)
                    quiesce();
            end
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Result side backpressure: modes switch after a random run, stalls capped
    initial
    begin
        ready_mode_e mode;
        int          mode_left;
        int          stall_run;
        int          tick;
        logic        rdy;
        rsp_ch.ready <= 1'b0;
        mode      = STREAM;
        mode_left = 0;
        stall_run = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = ready_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            tick++;
            case (mode)
                STREAM:       rdy = 1'b1;
                COIN:         rdy = 1'($urandom_range(0, 1));
                EVERY_FOURTH: rdy = (tick % 4) == 0;
                default:      rdy = ($urandom_range(0, 7) == 0);
            endcase
            if (stall_run >= MAX_STALL)
                rdy = 1'b1;
            stall_run = rdy ? 0 : stall_run + 1;
            rsp_ch.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("report beat with no request outstanding");
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("start_minute", int'(want.start_minute), int'(rsp_ch.start_minute));
                check_field("end_minute", int'(want.end_minute), int'(rsp_ch.end_minute));
                check_field("selected_valid", int'(want.selected_valid),
                            int'(rsp_ch.selected_valid));
                check_field("any_set", int'(want.any_set), int'(rsp_ch.any_set));
                check_field("warm_now", int'(want.warm_now), int'(rsp_ch.warm_now));
                check_field("warm_soon", int'(want.warm_soon), int'(rsp_ch.warm_soon));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

endmodule
